// ----- design/atv_pkg.sv -----
// Shared constants, tables and types for the additive tone voice.
// Holds the quarter-wave sine table, note tables and the divider request type.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package atv_pkg;

    // Field and register widths
    localparam int NOTE_W      = 7;
    localparam int VEL_W       = 9;
    localparam int LEN_W       = 24;
    localparam int OFFSET_W    = 24;
    localparam int SAMPLE_W    = 16;
    localparam int INV_SR_W    = 20;
    localparam int RAMP_W      = 16;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 2;

    localparam logic [INV_SR_W-1:0] INV_SR_RESET  = INV_SR_W'(97392);
    localparam logic [RAMP_W-1:0]   ATTACK_RESET  = RAMP_W'(441);
    localparam logic [RAMP_W-1:0]   RELEASE_RESET = RAMP_W'(3528);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_INV_SAMPLE_RATE = 2'd0,
        CFG_ATTACK_SAMPLES  = 2'd1,
        CFG_RELEASE_SAMPLES = 2'd2
    } cfg_idx_t;

    // Phase arithmetic
    localparam int FREQ_W     = 28;                 // Q4.24 Hz, one octave
    localparam int OCT_W      = 4;
    localparam int SEMI_W     = 4;
    localparam int PROD_W     = FREQ_W + INV_SR_W;  // base * inv_sample_rate
    localparam int STEP_W     = 56;                 // Q0.56 turns
    localparam int STEP_HALF  = STEP_W / 2;
    localparam int LO_W       = STEP_HALF + OFFSET_W;
    localparam int PHASE_W    = 32;                 // Q0.32 turns

    // Sine table (power-of-two depth)
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_QUARTER     = SINE_TABLE_DEPTH / 4;
    localparam int SINE_SHIFT       = PHASE_W - SINE_IDX_W;
    localparam int SINE_MAG_W       = 31;
    localparam int SINE_W           = 32;

    // Mixing and output scaling
    localparam int WP_W       = 48;
    localparam int MAG_W      = 46;
    localparam int VEL_SHIFT  = 23;
    localparam int MV_FULL_W  = MAG_W + VEL_W;
    localparam int MV_W       = MV_FULL_W - VEL_SHIFT;
    localparam int OUT_SHIFT  = 33;

    localparam logic signed [15:0] HARM_W1 = 16'sd18022;
    localparam logic signed [15:0] HARM_W2 = 16'sd5898;
    localparam logic signed [15:0] HARM_W3 = 16'sd2621;

    // Envelope: Q0.16 with one guard bit so that 1.0 is representable
    localparam int ENV_FRAC_W = 16;
    localparam int ENV_W      = ENV_FRAC_W + 1;
    localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(65536);

    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = ENV_FRAC_W / DIV_BITS_PER_STAGE;

    typedef struct packed {
        logic [RAMP_W-1:0] num;
        logic [RAMP_W-1:0] den;
        logic              bypass;
    } div_req_t;

    // Note number to octave and semitone
    localparam int NOTE_COUNT = 2 ** NOTE_W;
    typedef logic [NOTE_COUNT-1:0][OCT_W-1:0]  note_oct_tab_t;
    typedef logic [NOTE_COUNT-1:0][SEMI_W-1:0] note_semi_tab_t;

    function automatic note_oct_tab_t build_note_oct();
        note_oct_tab_t tab;
        for (int i = 0; i < NOTE_COUNT; i++) begin
            tab[i] = OCT_W'(i / 12);
        end
        return tab;
    endfunction

    function automatic note_semi_tab_t build_note_semi();
        note_semi_tab_t tab;
        for (int i = 0; i < NOTE_COUNT; i++) begin
            tab[i] = SEMI_W'(i % 12);
        end
        return tab;
    endfunction

    localparam note_oct_tab_t  NOTE_OCT  = build_note_oct();
    localparam note_semi_tab_t NOTE_SEMI = build_note_semi();

    // Frequencies of notes 0..11 in Q4.24 Hz
    function automatic logic [FREQ_W-1:0] base_freq(input logic [SEMI_W-1:0] semi);
        logic [FREQ_W-1:0] f;
        unique case (semi)
            4'd0:    f = 28'd137167144;
            4'd1:    f = 28'd145323527;
            4'd2:    f = 28'd153964914;
            4'd3:    f = 28'd163120144;
            4'd4:    f = 28'd172819773;
            4'd5:    f = 28'd183096171;
            4'd6:    f = 28'd193983636;
            4'd7:    f = 28'd205518503;
            4'd8:    f = 28'd217739269;
            4'd9:    f = 28'd230686720;
            4'd10:   f = 28'd244404066;
            4'd11:   f = 28'd258937088;
            default: f = '0;
        endcase
        return f;
    endfunction

    // Quarter-wave sine, Q1.30, evaluated only while building the table
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    function automatic logic [63:0] quarter_sine(input logic [63:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        return (x * t) >> 30;
    endfunction

    typedef logic [SINE_QUARTER:0][SINE_MAG_W-1:0] qsine_tab_t;

    function automatic qsine_tab_t build_qsine();
        qsine_tab_t  tab;
        logic [63:0] q;
        for (int k = 0; k <= SINE_QUARTER; k++) begin
            q      = quarter_sine(64'(k) << SINE_SHIFT);
            tab[k] = q[SINE_MAG_W-1:0];
        end
        return tab;
    endfunction

    localparam qsine_tab_t QSINE = build_qsine();

    // Full-wave lookup: fold the index onto the quarter table, restore the sign
    function automatic logic signed [SINE_W-1:0] sine_at(input logic [SINE_IDX_W-1:0] idx);
        logic [SINE_IDX_W-2:0] k;
        logic [SINE_MAG_W-1:0] mag;
        k = idx[SINE_IDX_W-2]
            ? (SINE_IDX_W-1)'(SINE_QUARTER) - {1'b0, idx[SINE_IDX_W-3:0]}
            : {1'b0, idx[SINE_IDX_W-3:0]};
        mag = QSINE[k];
        return idx[SINE_IDX_W-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

`default_nettype wire

// ----- design/atv_div.sv -----
// Pipelined restoring divider for the envelope ratio num * 2^16 / den.
// Depends on atv_pkg (widths, div_req_t); stage enables come from the top level.
`timescale 1ns / 1ps
`default_nettype none

module atv_div (
    input  wire logic                            aclk,
    input  wire logic [atv_pkg::DIV_STAGES-1:0]  en,
    input  wire atv_pkg::div_req_t               req,
    output logic      [atv_pkg::ENV_W-1:0]       env
);
    import atv_pkg::*;

    typedef struct packed {
        logic [RAMP_W-1:0]     rem;
        logic [RAMP_W-1:0]     den;
        logic [ENV_FRAC_W-1:0] quo;
        logic                  bypass;
    } div_stage_t;

    div_stage_t stage_in   [DIV_STAGES];
    div_stage_t stage_next [DIV_STAGES];
    div_stage_t stage_reg  [DIV_STAGES];

    always_comb begin
        stage_in[0].rem    = req.num;
        stage_in[0].den    = req.den;
        stage_in[0].quo    = '0;
        stage_in[0].bypass = req.bypass;
        for (int k = 1; k < DIV_STAGES; k++) begin
            stage_in[k] = stage_reg[k-1];
        end
    end

    // Numerator is below the divisor, so each step yields exactly one quotient bit
    always_comb begin
        div_stage_t    cur;
        logic [RAMP_W:0] trial;
        for (int k = 0; k < DIV_STAGES; k++) begin
            cur = stage_in[k];
            for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
                trial = {cur.rem, 1'b0};
                if (trial >= {1'b0, cur.den}) begin
                    cur.rem = RAMP_W'(trial - {1'b0, cur.den});
                    cur.quo = {cur.quo[ENV_FRAC_W-2:0], 1'b1};
                end else begin
                    cur.rem = trial[RAMP_W-1:0];
                    cur.quo = {cur.quo[ENV_FRAC_W-2:0], 1'b0};
                end
            end
            stage_next[k] = cur;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (en[k]) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign env = stage_reg[DIV_STAGES-1].bypass
                 ? ENV_ONE
                 : {1'b0, stage_reg[DIV_STAGES-1].quo};

endmodule

`default_nettype wire

// ----- design/additive_tone_voice_with_envelope.sv -----
// Additive tone voice: three-harmonic sine sum with linear attack/release envelope.
// Depends on atv_pkg (tables, widths) and atv_div (pipelined envelope divider).
//
//  Channel   Ports                                   Direction  Moves
//  s_        s_valid/s_ready, note, vel, len, off    in         one request per sample
//  m_        m_valid/m_ready, m_sample_value         out        one Q1.15 sample
//  cfg_      cfg_wr_en, cfg_index, cfg_wdata         in         register write, no wait
//
//  Thirteen register stages; an accepted request passes through all of them to reach m_valid.
//  One request per clock while m_ready lets the output drain: every multiplier and the 8-stage divider are pipelined.
//  Reset (synchronous, active low) clears stage valids and loads the register defaults.
//  A stall closes up bubbles: a stage loads whenever it is empty or the next one loads.
//  s_ready follows m_ready combinationally through that valid chain.
`timescale 1ns / 1ps
`default_nettype none

module additive_tone_voice_with_envelope (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration writes
    input  wire logic                               cfg_wr_en,
    input  wire logic [atv_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [atv_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // request channel
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [atv_pkg::NOTE_W-1:0]         s_midi_note,
    input  wire logic [atv_pkg::VEL_W-1:0]          s_velocity,
    input  wire logic [atv_pkg::LEN_W-1:0]          s_note_length,
    input  wire logic [atv_pkg::OFFSET_W-1:0]       s_sample_offset,
    // sample channel
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [atv_pkg::SAMPLE_W-1:0]     m_sample_value
);
    import atv_pkg::*;

    // Stage numbering: divider occupies ST_DIV0 .. ST_DIV0+DIV_STAGES-1,
    // its result is taken alongside the velocity multiply in ST_MV.
    localparam int ST_DIV0   = 2;
    localparam int ST_MV     = ST_DIV0 + DIV_STAGES;
    localparam int ST_SCALE  = ST_MV + 1;
    localparam int ST_OUT    = ST_SCALE + 1;
    localparam int NSTAGES   = ST_OUT + 1;

    localparam logic [MV_W+ENV_W-OUT_SHIFT:0] SAT_MAX = (MV_W+ENV_W-OUT_SHIFT+1)'(32767);

    // Stage payloads
    typedef struct packed {
        logic [FREQ_W-1:0]   base;
        logic [OCT_W-1:0]    oct;
        logic [OFFSET_W-1:0] off;
        logic [VEL_W-1:0]    vel;
        logic                att_hit;
        logic [LEN_W-1:0]    rem;
    } s0_t;

    typedef struct packed {
        logic [PROD_W-1:0]   prod;
        logic [OCT_W-1:0]    oct;
        logic [OFFSET_W-1:0] off;
        logic [VEL_W-1:0]    vel;
        div_req_t            env_req;
    } s1_t;

    typedef struct packed {
        logic [STEP_W-1:0]   step;
        logic [OFFSET_W-1:0] off;
        logic [VEL_W-1:0]    vel;
    } s2_t;

    typedef struct packed {
        logic [LO_W-1:0]      lo;
        logic [STEP_HALF-1:0] hi;
        logic [VEL_W-1:0]     vel;
    } s3_t;

    typedef struct packed {
        logic [PHASE_W-1:0] p;
        logic [VEL_W-1:0]   vel;
    } s4_t;

    typedef struct packed {
        logic [SINE_IDX_W-1:0] idx1;
        logic [SINE_IDX_W-1:0] idx2;
        logic [SINE_IDX_W-1:0] idx3;
        logic [VEL_W-1:0]      vel;
    } s5_t;

    typedef struct packed {
        logic signed [SINE_W-1:0] sin1;
        logic signed [SINE_W-1:0] sin2;
        logic signed [SINE_W-1:0] sin3;
        logic [VEL_W-1:0]         vel;
    } s6_t;

    typedef struct packed {
        logic signed [WP_W-1:0] wp1;
        logic signed [WP_W-1:0] wp2;
        logic signed [WP_W-1:0] wp3;
        logic [VEL_W-1:0]       vel;
    } s7_t;

    typedef struct packed {
        logic signed [WP_W-1:0] sum;
        logic [VEL_W-1:0]       vel;
    } s8_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [VEL_W-1:0] vel;
    } s9_t;

    typedef struct packed {
        logic             neg;
        logic [MV_W-1:0]  mv;
        logic [ENV_W-1:0] env;
    } s10_t;

    typedef struct packed {
        logic                   neg;
        logic [MV_W+ENV_W-1:0]  scaled;
    } s11_t;

    // Configuration registers
    logic [INV_SR_W-1:0] inv_sample_rate_reg;
    logic [RAMP_W-1:0]   attack_samples_reg;
    logic [RAMP_W-1:0]   release_samples_reg;

    // Pipeline control
    logic [NSTAGES-1:0] valid_reg;
    logic [NSTAGES-1:0] valid_next;
    logic [NSTAGES-1:0] load;

    s0_t  s0_reg,  s0_next;
    s1_t  s1_reg,  s1_next;
    s2_t  s2_reg,  s2_next;
    s3_t  s3_reg,  s3_next;
    s4_t  s4_reg,  s4_next;
    s5_t  s5_reg,  s5_next;
    s6_t  s6_reg,  s6_next;
    s7_t  s7_reg,  s7_next;
    s8_t  s8_reg,  s8_next;
    s9_t  s9_reg,  s9_next;
    s10_t s10_reg, s10_next;
    s11_t s11_reg, s11_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;

    logic [ENV_W-1:0] div_env;

    // ------------------------------------------------------------------
    // Configuration: take writes at once, drop unknown indexes
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_sample_rate_reg <= INV_SR_RESET;
            attack_samples_reg  <= ATTACK_RESET;
            release_samples_reg <= RELEASE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_INV_SAMPLE_RATE: inv_sample_rate_reg <= cfg_wdata[INV_SR_W-1:0];
                CFG_ATTACK_SAMPLES:  attack_samples_reg  <= cfg_wdata[RAMP_W-1:0];
                CFG_RELEASE_SAMPLES: release_samples_reg <= cfg_wdata[RAMP_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Valid chain: a stage loads when it is empty or its successor loads,
    // so bubbles collapse under back-pressure and nothing is lost.
    // ------------------------------------------------------------------
    always_comb begin
        load[NSTAGES-1] = !valid_reg[NSTAGES-1] || m_ready;
        for (int k = NSTAGES - 2; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    always_comb begin
        valid_next[0] = load[0] ? s_valid : valid_reg[0];
        for (int k = 1; k < NSTAGES; k++) begin
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = load[0];
    assign m_valid = valid_reg[ST_OUT];

    // ------------------------------------------------------------------
    // Stage 0: split the note into octave and semitone, fetch the base
    // frequency; start the envelope decision (attack test, remaining length).
    // ------------------------------------------------------------------
    always_comb begin
        s0_next.base    = base_freq(NOTE_SEMI[s_midi_note]);
        s0_next.oct     = NOTE_OCT[s_midi_note];
        s0_next.off     = s_sample_offset;
        s0_next.vel     = s_velocity;
        s0_next.att_hit = s_sample_offset < OFFSET_W'(attack_samples_reg);
        s0_next.rem     = (s_note_length > s_sample_offset)
                          ? s_note_length - s_sample_offset : '0;
    end

    // Stage 1: base * inv_sample_rate; pick the envelope ramp for the divider.
    always_comb begin
        s1_next.prod = PROD_W'(s0_reg.base) * PROD_W'(inv_sample_rate_reg);
        s1_next.oct  = s0_reg.oct;
        s1_next.off  = s0_reg.off;
        s1_next.vel  = s0_reg.vel;
        priority if (s0_reg.att_hit) begin
            // attack: offset is below the ramp length, so it fits the ramp width
            s1_next.env_req.num    = s0_reg.off[RAMP_W-1:0];
            s1_next.env_req.den    = attack_samples_reg;
            s1_next.env_req.bypass = 1'b0;
        end else if (s0_reg.rem < LEN_W'(release_samples_reg)) begin
            s1_next.env_req.num    = s0_reg.rem[RAMP_W-1:0];
            s1_next.env_req.den    = release_samples_reg;
            s1_next.env_req.bypass = 1'b0;
        end else begin
            // sustain: full level, divider result ignored
            s1_next.env_req.num    = '0;
            s1_next.env_req.den    = release_samples_reg;
            s1_next.env_req.bypass = 1'b1;
        end
    end

    // Stage 2: shift by the octave to form the phase step, modulo one turn.
    always_comb begin
        s2_next.step = STEP_W'(s1_reg.prod) << s1_reg.oct;
        s2_next.off  = s1_reg.off;
        s2_next.vel  = s1_reg.vel;
    end

    // Stage 3: step * offset as two half-width partial products;
    // the upper one only matters below the turn boundary.
    always_comb begin
        logic [LO_W-1:0] hi_full;
        hi_full      = LO_W'(s2_reg.step[STEP_W-1:STEP_HALF]) * LO_W'(s2_reg.off);
        s3_next.lo   = LO_W'(s2_reg.step[STEP_HALF-1:0]) * LO_W'(s2_reg.off);
        s3_next.hi   = hi_full[STEP_HALF-1:0];
        s3_next.vel  = s2_reg.vel;
    end

    // Stage 4: combine the partial products, keep the top 32 bits of the phase.
    always_comb begin
        logic [STEP_W-1:0] phase;
        phase       = STEP_W'(s3_reg.lo) + {s3_reg.hi, {STEP_HALF{1'b0}}};
        s4_next.p   = phase[STEP_W-1 -: PHASE_W];
        s4_next.vel = s3_reg.vel;
    end

    // Stage 5: harmonic phases (1x, 2x, 3x, each wrapping) and table indexes.
    always_comb begin
        logic [PHASE_W-1:0] p2;
        logic [PHASE_W-1:0] p3;
        p2           = {s4_reg.p[PHASE_W-2:0], 1'b0};
        p3           = s4_reg.p + p2;
        s5_next.idx1 = s4_reg.p[PHASE_W-1 -: SINE_IDX_W];
        s5_next.idx2 = p2[PHASE_W-1 -: SINE_IDX_W];
        s5_next.idx3 = p3[PHASE_W-1 -: SINE_IDX_W];
        s5_next.vel  = s4_reg.vel;
    end

    // Stage 6: three reads of the folded sine table.
    always_comb begin
        s6_next.sin1 = sine_at(s5_reg.idx1);
        s6_next.sin2 = sine_at(s5_reg.idx2);
        s6_next.sin3 = sine_at(s5_reg.idx3);
        s6_next.vel  = s5_reg.vel;
    end

    // Stage 7: apply the harmonic weights.
    always_comb begin
        s7_next.wp1 = WP_W'(s6_reg.sin1) * WP_W'(HARM_W1);
        s7_next.wp2 = WP_W'(s6_reg.sin2) * WP_W'(HARM_W2);
        s7_next.wp3 = WP_W'(s6_reg.sin3) * WP_W'(HARM_W3);
        s7_next.vel = s6_reg.vel;
    end

    // Stage 8: mix.
    always_comb begin
        s8_next.sum = s7_reg.wp1 + s7_reg.wp2 + s7_reg.wp3;
        s8_next.vel = s7_reg.vel;
    end

    // Stage 9: sign and magnitude; scaling works on the magnitude.
    always_comb begin
        s9_next.neg = s8_reg.sum[WP_W-1];
        s9_next.mag = s8_reg.sum[WP_W-1] ? MAG_W'(-s8_reg.sum) : MAG_W'(s8_reg.sum);
        s9_next.vel = s8_reg.vel;
    end

    // Stage 10: velocity gain, truncated; pick up the finished envelope.
    always_comb begin
        logic [MV_FULL_W-1:0] mv_full;
        mv_full      = MV_FULL_W'(s9_reg.mag) * MV_FULL_W'(s9_reg.vel);
        s10_next.mv  = mv_full[VEL_SHIFT +: MV_W];
        s10_next.neg = s9_reg.neg;
        s10_next.env = div_env;
    end

    // Stage 11: envelope gain.
    always_comb begin
        s11_next.scaled = (MV_W+ENV_W)'(s10_reg.mv) * (MV_W+ENV_W)'(s10_reg.env);
        s11_next.neg    = s10_reg.neg;
    end

    // Stage 12: round half away from zero (includes the 0.25 scale),
    // saturate the magnitude, restore the sign.
    always_comb begin
        logic [MV_W+ENV_W:0]           rnd;
        logic [MV_W+ENV_W-OUT_SHIFT:0] res;
        logic [SAMPLE_W-1:0]           mag_sat;
        rnd     = (MV_W+ENV_W+1)'(s11_reg.scaled) + ((MV_W+ENV_W+1)'(1) << (OUT_SHIFT - 1));
        res     = rnd[MV_W+ENV_W:OUT_SHIFT];
        mag_sat = (res > SAT_MAX) ? SAMPLE_W'(SAT_MAX) : SAMPLE_W'(res);
        sample_next = s11_reg.neg ? $signed(-mag_sat) : $signed(mag_sat);
    end

    // Payload registers: advance with their stage, hold otherwise
    always_ff @(posedge aclk) begin
        if (load[0])        s0_reg     <= s0_next;
        if (load[1])        s1_reg     <= s1_next;
        if (load[2])        s2_reg     <= s2_next;
        if (load[3])        s3_reg     <= s3_next;
        if (load[4])        s4_reg     <= s4_next;
        if (load[5])        s5_reg     <= s5_next;
        if (load[6])        s6_reg     <= s6_next;
        if (load[7])        s7_reg     <= s7_next;
        if (load[8])        s8_reg     <= s8_next;
        if (load[9])        s9_reg     <= s9_next;
        if (load[ST_MV])    s10_reg    <= s10_next;
        if (load[ST_SCALE]) s11_reg    <= s11_next;
        if (load[ST_OUT])   sample_reg <= sample_next;
    end

    // Envelope divider runs alongside the phase stages
    atv_div u_div (
        .aclk (aclk),
        .en   (load[ST_DIV0 +: DIV_STAGES]),
        .req  (s1_reg.env_req),
        .env  (div_env)
    );

    assign m_sample_value = sample_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // An accepted request must occupy the first stage on the next cycle.
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> valid_reg[0])
        else $error("accepted request did not enter stage 0");

    // With an empty output stage the whole chain must be able to advance.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[ST_OUT] |-> s_ready)
        else $error("input stalled while output stage is empty");

    // A stalled stage must keep both its valid and its payload.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[ST_SCALE] && !load[ST_SCALE] |=> valid_reg[ST_SCALE] && $stable(s11_reg))
        else $error("stalled scale stage lost or changed its request");

    // Saturation is symmetric: the most negative code never appears.
    a_symmetric_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_sample_value != {1'b1, {(SAMPLE_W-1){1'b0}}})
        else $error("sample outside symmetric saturation range");

endmodule

`default_nettype wire

// ----- dv/additive_tone_voice_with_envelope_test.sv -----
// Self-checking bench for the additive tone voice: one request in, one Q1.15 sample out.
// Predicts every sample in-bench. Depends on atv_pkg for widths and the register index codes.
`timescale 1ns / 1ps

module additive_tone_voice_with_envelope_test;

    import atv_pkg::*;

    // Bench constants: table depth, fixed-point units, run limits
    localparam int          TONE_DEPTH       = 1024;
    localparam int          TONE_BITS        = 10;
    localparam bit [63:0]   PHASE_MASK56     = 64'h00FF_FFFF_FFFF_FFFF;
    localparam bit [63:0]   UNIT_Q30         = 64'd1073741824;
    localparam bit [63:0]   PI_OVER_2_Q30    = 64'd1686629713;
    localparam bit [63:0]   LEVEL_FULL       = 64'd65536;
    localparam bit [63:0]   TAYLOR_DIV [5]   = '{110, 72, 42, 20, 6};
    localparam longint      MIX_FUND         = 18022;
    localparam longint      MIX_SECOND       = 5898;
    localparam longint      MIX_THIRD        = 2621;
    localparam bit [31:0]   NOTE_HZ_Q24 [12] = '{
        137167144, 145323527, 153964914, 163120144, 172819773, 183096171,
        193983636, 205518503, 217739269, 230686720, 244404066, 258937088
    };
    localparam int          PHASES           = 8;
    localparam int          PER_PHASE        = 235;
    localparam int          HOLD_AFTER       = 500;
    localparam int          HOLD_CYCLES      = 400;
    localparam int          QUIET_LIMIT      = 4000;
    localparam int          TAIL_CYCLES      = 24;
    localparam bit [23:0]   OFFSET_MAX       = 24'hFF_FFFF;

    // Register index with no register behind it
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE = 2'd3;

    typedef struct packed {
        logic [NOTE_W-1:0]   midi_note;
        logic [VEL_W-1:0]    velocity;
        logic [LEN_W-1:0]    note_length;
        logic [OFFSET_W-1:0] sample_offset;
    } voice_request_t;

    typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic [CFG_INDEX_W-1:0]     reg_index;
        logic [CFG_DATA_W-1:0]      reg_value;
        voice_request_t             req;
        logic                       known;
        logic signed [SAMPLE_W-1:0] want;
    } stimulus_row_t;

    // Directed part. Rows marked known carry a sample read straight off the
    // envelope or phase (silence); the rest go through the predictor.
    localparam stimulus_row_t DIRECTED [30] = '{
        // reset settings: silent attack start, zero velocity, end of note
        '{ROW_REQUEST, '0, '0, '{7'd69,  9'd256, 24'd100000,   24'd0},        1'b1, 16'sd0},
        '{ROW_REQUEST, '0, '0, '{7'd0,   9'd0,   24'd100000,   24'd1000},     1'b1, 16'sd0},
        '{ROW_REQUEST, '0, '0, '{7'd127, 9'd511, 24'd16777215, 24'd16777215}, 1'b1, 16'sd0},
        '{ROW_REQUEST, '0, '0, '{7'd0,   9'd511, 24'd0,        24'd0},        1'b1, 16'sd0},
        '{ROW_REQUEST, '0, '0, '{7'd127, 9'd511, 24'd16777215, 24'd5000},     1'b0, '0},
        '{ROW_REQUEST, '0, '0, '{7'd69,  9'd256, 24'd100000,   24'd200},      1'b0, '0},
        '{ROW_REQUEST, '0, '0, '{7'd69,  9'd256, 24'd100000,   24'd441},      1'b0, '0},
        '{ROW_REQUEST, '0, '0, '{7'd60,  9'd300, 24'd100000,   24'd98000},    1'b0, '0},
        '{ROW_REQUEST, '0, '0, '{7'd60,  9'd128, 24'd100000,   24'd100000},   1'b1, 16'sd0},
        '{ROW_REQUEST, '0, '0, '{7'd0,   9'd256, 24'd0,        24'd500},      1'b1, 16'sd0},
        '{ROW_REQUEST, '0, '0, '{7'd127, 9'd256, 24'd16777215, 24'd8388608},  1'b0, '0},
        '{ROW_REQUEST, '0, '0, '{7'd12,  9'd1,   24'd50000,    24'd10000},    1'b0, '0},
        '{ROW_REQUEST, '0, '0, '{7'd100, 9'd257, 24'd4028,     24'd500},      1'b0, '0},
        '{ROW_REQUEST, '0, '0, '{7'd45,  9'd256, 24'd10000,    24'd6473},     1'b0, '0},
        // no attack: release test applies from the first sample
        '{ROW_WRITE, CFG_ATTACK_SAMPLES, 20'd0, '0, 1'b0, '0},
        '{ROW_REQUEST, '0, '0, '{7'd69,  9'd256, 24'd100000,   24'd1},        1'b0, '0},
        '{ROW_REQUEST, '0, '0, '{7'd69,  9'd256, 24'd100,      24'd0},        1'b1, 16'sd0},
        // no release: full level even past the note end
        '{ROW_WRITE, CFG_RELEASE_SAMPLES, 20'd0, '0, 1'b0, '0},
        '{ROW_REQUEST, '0, '0, '{7'd33,  9'd200, 24'd10,       24'd5},        1'b0, '0},
        '{ROW_REQUEST, '0, '0, '{7'd33,  9'd200, 24'd10,       24'd20},       1'b0, '0},
        // unmapped index must leave every register alone
        '{ROW_WRITE, CFG_INDEX_SPARE, 20'hFFFFF, '0, 1'b0, '0},
        '{ROW_REQUEST, '0, '0, '{7'd50,  9'd256, 24'd100000,   24'd777},      1'b0, '0},
        // zero phase step: every harmonic sits at sine zero
        '{ROW_WRITE, CFG_INV_SAMPLE_RATE, 20'd0, '0, 1'b0, '0},
        '{ROW_REQUEST, '0, '0, '{7'd81,  9'd511, 24'd16777215, 24'd12345},    1'b1, 16'sd0},
        // register extremes
        '{ROW_WRITE, CFG_INV_SAMPLE_RATE, 20'hFFFFF, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_ATTACK_SAMPLES,  20'h0FFFF, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_RELEASE_SAMPLES, 20'h0FFFF, '0, 1'b0, '0},
        '{ROW_REQUEST, '0, '0, '{7'd127, 9'd511, 24'd16777215, 24'd65535},    1'b0, '0},
        '{ROW_REQUEST, '0, '0, '{7'd1,   9'd256, 24'd16777215, 24'd16777115}, 1'b0, '0},
        '{ROW_REQUEST, '0, '0, '{7'd90,  9'd256, 24'd200000,   24'd70000},    1'b0, '0}
    };

    // Clock, reset and DUT-facing signals; those the bench drives are known from time zero
    logic                       aclk            = 1'b0;
    logic                       aresetn         = 1'b0;
    logic                       cfg_wr_en       = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index       = '0;
    logic [CFG_DATA_W-1:0]      cfg_wdata       = '0;
    logic                       s_valid         = 1'b0;
    logic                       s_ready;
    logic [NOTE_W-1:0]          s_midi_note     = '0;
    logic [VEL_W-1:0]           s_velocity      = '0;
    logic [LEN_W-1:0]           s_note_length   = '0;
    logic [OFFSET_W-1:0]        s_sample_offset = '0;
    logic                       m_valid;
    logic                       m_ready         = 1'b0;
    logic signed [SAMPLE_W-1:0] m_sample_value;

    // Bench copy of the voice registers
    bit [INV_SR_W-1:0] inv_rate    = INV_SR_RESET;
    bit [RAMP_W-1:0]   attack_len  = ATTACK_RESET;
    bit [RAMP_W-1:0]   release_len = RELEASE_RESET;

    int tone_q30 [TONE_DEPTH];

    // Samples owed by the block, oldest first
    logic signed [SAMPLE_W-1:0] expected_samples [$];
    logic signed [SAMPLE_W-1:0] sample_due;
    int                         errors       = 0;
    int                         samples_seen = 0;

    // Sender burst state and receiver stall state
    int       burst_left  = 0;
    int       hold_left   = 0;
    bit       hold_done   = 1'b0;
    bit [8:0] stall_tick  = '0;
    int       quiet_cycles = 0;

    additive_tone_voice_with_envelope i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_midi_note     (s_midi_note),
        .s_velocity      (s_velocity),
        .s_note_length   (s_note_length),
        .s_sample_offset (s_sample_offset),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample_value  (m_sample_value)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Full-wave sine table in Q1.30: fold each entry onto the quarter wave and
    // evaluate a Taylor series to x^11 in nested form.
    initial begin : build_tone_table
        bit [63:0] turn;
        bit [63:0] frac;
        bit [63:0] x;
        bit [63:0] x2;
        bit [63:0] t;
        for (int i = 0; i < TONE_DEPTH; i++) begin
            turn = (64'(i) << 32) / TONE_DEPTH;
            frac = turn & (UNIT_Q30 - 1);
            if (turn[30]) begin
                frac = UNIT_Q30 - frac;
            end
            x  = (frac * PI_OVER_2_Q30) >> 30;
            x2 = (x * x) >> 30;
            t  = UNIT_Q30;
            for (int k = 0; k < 5; k++) begin
                t = UNIT_Q30 - ((x2 * t) >> 30) / TAYLOR_DIV[k];
            end
            t = (x * t) >> 30;
            tone_q30[i] = turn[31] ? -int'(t) : int'(t);
        end
    end

    // Work out the sample one request must produce under the current registers
    function automatic logic signed [SAMPLE_W-1:0] voice_sample(input voice_request_t r);
        bit [63:0] freq;
        bit [63:0] step;
        bit [63:0] phase;
        bit [31:0] ph1;
        bit [31:0] ph2;
        bit [31:0] ph3;
        bit [63:0] offs;
        bit [63:0] len;
        bit [63:0] remaining;
        bit [63:0] level;
        bit [63:0] mag;
        bit [63:0] amp;
        longint    mix;
        bit        neg;
        freq  = 64'(NOTE_HZ_Q24[r.midi_note % 12]) << (r.midi_note / 12);
        step  = (freq * 64'(inv_rate)) & PHASE_MASK56;
        offs  = 64'(r.sample_offset);
        len   = 64'(r.note_length);
        phase = (step * offs) & PHASE_MASK56;
        ph1   = phase[55:24];
        ph2   = ph1 << 1;
        ph3   = ph1 + ph2;
        mix   = MIX_FUND   * longint'(tone_q30[ph1[31 -: TONE_BITS]])
              + MIX_SECOND * longint'(tone_q30[ph2[31 -: TONE_BITS]])
              + MIX_THIRD  * longint'(tone_q30[ph3[31 -: TONE_BITS]]);
        // Attack ramp first; past it, release over the last samples of the note
        if (offs < 64'(attack_len)) begin
            level = (offs * LEVEL_FULL) / 64'(attack_len);
        end else begin
            remaining = (len > offs) ? len - offs : 64'd0;
            if (remaining < 64'(release_len)) begin
                level = (remaining * LEVEL_FULL) / 64'(release_len);
            end else begin
                level = LEVEL_FULL;
            end
        end
        neg = mix < 0;
        mag = neg ? 64'(-mix) : 64'(mix);
        // Velocity gain, envelope, then round half away from zero by 33 bits
        amp = ((mag * 64'(r.velocity)) >> 23) * level;
        amp = (amp + (64'd1 << 32)) >> 33;
        if (amp > 64'd32767) begin
            amp = 64'd32767;
        end
        return neg ? SAMPLE_W'(64'd0 - amp) : SAMPLE_W'(amp);
    endfunction

    // Offer one request, sometimes idling first when the current burst has run out.
    // Returns at the edge that accepts it, with s_valid still high.
    task automatic send_request(input voice_request_t r, input logic known,
                                input logic signed [SAMPLE_W-1:0] want);
        int                         gap;
        logic signed [SAMPLE_W-1:0] owed;
        gap = 0;
        if (burst_left == 0) begin
            gap        = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
            burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(300, 100)
                                                      : $urandom_range(30, 1);
        end
        burst_left--;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_midi_note     <= r.midi_note;
        s_velocity      <= r.velocity;
        s_note_length   <= r.note_length;
        s_sample_offset <= r.sample_offset;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        owed = known ? want : voice_sample(r);
        expected_samples.insert(expected_samples.size(), owed);
    endtask

    task automatic drain_samples();
        while (expected_samples.size() != 0) @(posedge aclk);
    endtask

    // One register write while the pipeline is empty, then track it in the copy
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_INV_SAMPLE_RATE: inv_rate    = data[INV_SR_W-1:0];
            CFG_ATTACK_SAMPLES:  attack_len  = data[RAMP_W-1:0];
            CFG_RELEASE_SAMPLES: release_len = data[RAMP_W-1:0];
            default: ; // unmapped index: drop it, as the block does
        endcase
    endtask

    // Compare each accepted sample with the oldest one owed
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: sample_value expected none, got %0d", $time, m_sample_value);
                errors++;
            end else begin
                sample_due = expected_samples.pop_front();
                if (m_sample_value !== sample_due) begin
                    $display("%0t: sample_value expected %0d, got %0d",
                             $time, sample_due, m_sample_value);
                    errors++;
                end
            end
            samples_seen <= samples_seen + 1;
        end
    end

    // Receiver: stall on a pattern picked by the upper bits of the stall tick, and once, after
    // enough samples, hold off long enough for the pipeline to fill and push back.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && samples_seen >= HOLD_AFTER) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            stall_tick <= stall_tick + 1'b1;
            case (stall_tick[8:6])
                3'd2:    m_ready <= $urandom_range(1, 0) == 1;
                3'd3:    m_ready <= stall_tick[1:0] == 2'd0;
                3'd4:    m_ready <= $urandom_range(9, 0) != 0;
                3'd5:    m_ready <= stall_tick[3];
                3'd6:    m_ready <= $urandom_range(3, 0) == 0;
                default: m_ready <= 1'b1;
            endcase
        end
    end

    // Watchdog: give up when nothing has moved for far longer than any stall
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("additive_tone_voice_with_envelope_test NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : run_voice
        voice_request_t              req;
        logic [INV_SR_W-1:0]         set_rate;
        logic [RAMP_W-1:0]           set_attack;
        logic [RAMP_W-1:0]           set_release;
        int unsigned                 pick;
        int unsigned                 span;
        int unsigned                 offs;
        int unsigned                 len;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows; writes wait for the pipeline to empty
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_WRITE) begin
                s_valid <= 1'b0;
                drain_samples();
                write_register(DIRECTED[i].reg_index, DIRECTED[i].reg_value);
            end else begin
                send_request(DIRECTED[i].req, DIRECTED[i].known, DIRECTED[i].want);
            end
        end

        // Random phases, each under its own register settings
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    set_rate = INV_SR_RESET; set_attack = ATTACK_RESET;
                    set_release = RELEASE_RESET;
                end
                1: begin
                    set_rate = '1; set_attack = 16'd1; set_release = 16'd1;
                end
                2: begin
                    set_rate = 20'd1; set_attack = '1; set_release = '1;
                end
                3: begin
                    set_rate    = INV_SR_W'($urandom_range(536871, 1));
                    set_attack  = '0;
                    set_release = '0;
                end
                default: begin
                    set_rate    = INV_SR_W'($urandom_range(536871, 1));
                    set_attack  = RAMP_W'(($urandom_range(3, 0) == 0)
                                          ? $urandom_range(65535, 0)
                                          : $urandom_range(2000, 1));
                    set_release = RAMP_W'(($urandom_range(3, 0) == 0)
                                          ? $urandom_range(65535, 0)
                                          : $urandom_range(8000, 1));
                end
            endcase
            s_valid <= 1'b0;
            drain_samples();
            write_register(CFG_INV_SAMPLE_RATE, CFG_DATA_W'(set_rate));
            write_register(CFG_ATTACK_SAMPLES,  CFG_DATA_W'(set_attack));
            write_register(CFG_RELEASE_SAMPLES, CFG_DATA_W'(set_release));

            for (int n = 0; n < PER_PHASE; n++) begin
                pick = $urandom_range(99, 0);
                req.midi_note = NOTE_W'($urandom_range(127, 0));
                req.velocity  = VEL_W'(($urandom_range(7, 0) == 0)
                                       ? $urandom_range(511, 257)
                                       : $urandom_range(256, 0));
                // Aim the offset at each envelope region in turn
                if (pick < 25) begin
                    // inside the attack ramp or at its end
                    offs = $urandom_range(attack_len, 0);
                    len  = $urandom_range(OFFSET_MAX, offs);
                end else if (pick < 50) begin
                    // across the release ramp and its edges
                    span = release_len + 2;
                    len  = $urandom_range(OFFSET_MAX, span);
                    offs = len - $urandom_range(span, 0);
                end else if (pick < 70) begin
                    // sustained part of a long note
                    offs = $urandom_range(OFFSET_MAX, 0);
                    len  = offs + $urandom_range(200000, 0);
                    if (len > OFFSET_MAX) begin
                        len = OFFSET_MAX;
                    end
                end else if (pick < 85) begin
                    // at or past the note end
                    offs = $urandom_range(OFFSET_MAX, 1);
                    len  = $urandom_range(offs, 0);
                end else begin
                    // raw fields, every bit free
                    req.midi_note = NOTE_W'($urandom());
                    req.velocity  = VEL_W'($urandom());
                    offs          = $urandom();
                    len           = $urandom();
                end
                req.sample_offset = OFFSET_W'(offs);
                req.note_length   = LEN_W'(len);
                send_request(req, 1'b0, '0);
            end
        end

        // Let the tail drain, then leave room for anything stray
        s_valid <= 1'b0;
        drain_samples();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (errors == 0 && expected_samples.size() == 0) begin
            $display("additive_tone_voice_with_envelope_test OK");
        end else begin
            $display("additive_tone_voice_with_envelope_test NOT OK");
        end
        $finish;
    end

endmodule
